/* sv/ewms_pkg.sv */
// package for the emulated wheel motor status block
// holds item and report types, opcodes, reset values and the target decode
// depends on nothing
`timescale 1ns / 1ps

package ewms_pkg;

	localparam int CMD_W      = 2;
	localparam int BYTE_W     = 8;
	localparam int POS_W      = 8;
	localparam int MS_W       = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;
	localparam int P16_W      = 16;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 40;

	typedef enum logic [CMD_W-1:0] {
		CMD_BYTES = 2'd0,
		CMD_TICK  = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	localparam logic [CFG_IDX_W-1:0] CFG_EMU_EN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BUSY_WIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TORQUE   = 2'd2;

	localparam logic [BYTE_W-1:0] OP_SET_TARGET = 8'h31;
	localparam logic [BYTE_W-1:0] OP_INIT       = 8'h30;
	localparam logic [BYTE_W-1:0] PARAM_MID     = 8'h80;
	localparam logic [BYTE_W-1:0] REPORT_OK     = 8'h01;

	localparam logic signed [POS_W-1:0] POS_LIMIT  = 8'sd100;
	localparam logic signed [POS_W-1:0] POS_NLIMIT = -8'sd100;
	localparam logic [MS_W-1:0]   MS_MAX       = 10'h3FF;
	localparam logic [MS_W-1:0]   BUSY_WIN_RST = 10'd500;
	localparam logic [BYTE_W-1:0] TORQUE_RST   = 8'h40;

	localparam logic signed [17:0] POS_SCALE  = 18'sd327;
	localparam logic signed [17:0] POS_CENTRE = 18'sh08000;

	typedef struct packed {
		cmd_t              cmd;
		logic [BYTE_W-1:0] first_byte;
		logic [BYTE_W-1:0] param_byte;
		logic              has_param;
	} item_t;

	typedef struct packed {
		logic              emu_en;
		logic [MS_W-1:0]   busy_win;
		logic [BYTE_W-1:0] torque;
	} cfg_t;

	// report request from the state stage to the output register
	typedef struct packed {
		logic                     valid;
		logic                     busy;
		logic signed [POS_W-1:0]  position;
		logic [BYTE_W-1:0]        torque;
	} rpt_req_t;

	// param byte to target: centre codes give 0, else +-50 plus half the offset, clamped
	function automatic logic signed [POS_W-1:0] target_from_param(input logic [BYTE_W-1:0] p);
		logic signed [8:0] t;
		logic signed [POS_W-1:0] r;
		t = 9'sd0;
		r = 8'sd0;
		if (p == 8'h00 || p == PARAM_MID) begin
			r = 8'sd0;
		end else if (p < PARAM_MID) begin
			t = -9'sd50 - $signed({2'b00, p[7:1]});
			r = (t < -9'sd100) ? POS_NLIMIT : t[POS_W-1:0];
		end else begin
			t = 9'sd50 + $signed({3'b000, p[6:1]});
			r = (t > 9'sd100) ? POS_LIMIT : t[POS_W-1:0];
		end
		return r;
	endfunction

endpackage

/* sv/ewms_state.sv */
// state stage: position, target and millisecond counter, updated per item
// builds the report request for status queries; uses ewms_pkg
`timescale 1ns / 1ps

module ewms_state (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  ewms_pkg::item_t     item,
	input  ewms_pkg::cfg_t      cfg,
	output ewms_pkg::rpt_req_t  req
);
	import ewms_pkg::*;

	logic signed [POS_W-1:0] cur_q;
	logic signed [POS_W-1:0] tgt_q;
	logic [MS_W-1:0]         ms_q;
	logic signed [POS_W-1:0] cur_d;
	logic signed [POS_W-1:0] tgt_d;
	logic [MS_W-1:0]         ms_d;

	always_comb begin
		cur_d = cur_q;
		tgt_d = tgt_q;
		ms_d  = ms_q;
		unique case (item.cmd)
			CMD_BYTES: begin
				ms_d = '0;
				if (item.has_param) begin
					if (item.first_byte == OP_SET_TARGET) begin
						tgt_d = target_from_param(item.param_byte);
					end else if (item.first_byte == OP_INIT) begin
						cur_d = '0;
						tgt_d = '0;
					end
				end
			end
			CMD_TICK: begin
				if (ms_q != MS_MAX) begin
					ms_d = ms_q + 1'b1;
				end
				if (cfg.emu_en) begin
					if (cur_q < tgt_q) begin
						cur_d = cur_q + 8'sd1;
					end else if (cur_q > tgt_q) begin
						cur_d = cur_q - 8'sd1;
					end
				end
			end
			CMD_QUERY: begin
			end
			CMD_NONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			tgt_q <= '0;
			ms_q  <= MS_MAX;
		end else if (fire) begin
			cur_q <= cur_d;
			tgt_q <= tgt_d;
			ms_q  <= ms_d;
		end
	end

	always_comb begin
		req.valid    = fire && (item.cmd == CMD_QUERY);
		req.busy     = (cur_q != tgt_q) && (ms_q < cfg.busy_win);
		req.position = cur_q;
		req.torque   = cfg.torque;
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_q >= POS_NLIMIT) && (cur_q <= POS_LIMIT))
		else $error("position out of range");

	a_tgt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(tgt_q >= POS_NLIMIT) && (tgt_q <= POS_LIMIT))
		else $error("target out of range");

	a_cmd_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item.cmd == CMD_BYTES) |=> (ms_q == '0))
		else $error("command did not restart counter");

endmodule

/* sv/ewms_report.sv */
// report stage: scales the position to a centred 16-bit value and holds
// the finished report until the master side takes it; uses ewms_pkg
`timescale 1ns / 1ps

module ewms_report (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ewms_pkg::rpt_req_t              req,
	output logic                            out_free,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ewms_pkg::OUT_DATA_W-1:0] m_tdata
);
	import ewms_pkg::*;

	logic signed [17:0]  p16_raw;
	logic [P16_W-1:0]    p16;
	logic [OUT_DATA_W-1:0] data_q;
	logic                valid_q;

	always_comb begin
		p16_raw = POS_CENTRE + ($signed({{10{req.position[POS_W-1]}}, req.position}) * POS_SCALE);
		if (p16_raw < 18'sd0) begin
			p16 = '0;
		end else if (p16_raw > 18'sh0FFFF) begin
			p16 = '1;
		end else begin
			p16 = p16_raw[P16_W-1:0];
		end
	end

	assign out_free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (req.valid) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// fields from bit 0: report_code, motor_busy, position_high, position_low, torque_out
	always_ff @(posedge clk) begin
		if (req.valid) begin
			data_q <= {7'd0, req.torque, p16[7:0], p16[15:8], req.busy, REPORT_OK};
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;

	a_req_shows: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid |=> m_tvalid)
		else $error("report request not shown");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !m_tready) |-> !req.valid)
		else $error("pending report overwritten");

	a_code_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:0] == REPORT_OK))
		else $error("bad report code");

endmodule

/* sv/emulated_wheel_motor_status_core.sv */
// top level of the emulated wheel motor status block
// holds the config registers and the input register; uses ewms_pkg,
// ewms_state and ewms_report
`timescale 1ns / 1ps

// Emulated force-feedback wheel motor. Each request on the slave side is a
// command (tuser 0), a one-millisecond tick (tuser 1) or a status query
// (tuser 2); tuser 3 is dropped. Only a query produces a report on the master
// side. A request is held in the input register, then updates the position,
// target and millisecond counter and, for a query, loads the report register
// that drives the master side. One request is taken every cycle; the rate
// drops only while a report waits in the output register and a further query
// reaches the state stage. Configuration writes (emulation enable, busy
// window, torque) take effect at once and should be made only while the
// block is idle.
module emulated_wheel_motor_status_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// config write port
	input  logic                            cfg_we,
	input  logic [ewms_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ewms_pkg::CFG_DATA_W-1:0] cfg_wdata,
	// slave side
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// from bit 0: first_byte[7:0], param_byte[15:8], has_param[16], zero pad
	input  logic [ewms_pkg::IN_DATA_W-1:0]  s_tdata,
	// from bit 0: cmd[1:0]
	input  logic [ewms_pkg::CMD_W-1:0]      s_tuser,
	// master side
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// from bit 0: report_code[7:0], motor_busy[8], position_high[16:9],
	// position_low[24:17], torque_out[32:25], zero pad
	output logic [ewms_pkg::OUT_DATA_W-1:0] m_tdata
);
	import ewms_pkg::*;

	cfg_t     cfg_q;
	item_t    item_s1;
	logic     valid_s1;
	logic     fire;
	logic     out_free;
	rpt_req_t req;

	// config registers, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.emu_en   <= 1'b0;
			cfg_q.busy_win <= BUSY_WIN_RST;
			cfg_q.torque   <= TORQUE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_EMU_EN:   cfg_q.emu_en   <= cfg_wdata[0];
				CFG_BUSY_WIN: cfg_q.busy_win <= cfg_wdata[MS_W-1:0];
				CFG_TORQUE:   cfg_q.torque   <= cfg_wdata[BYTE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// a held request leaves the input register unless it is a query blocked
	// by a report still waiting on the master side
	assign fire     = valid_s1 && ((item_s1.cmd != CMD_QUERY) || out_free);
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.cmd        <= cmd_t'(s_tuser);
			item_s1.first_byte <= s_tdata[7:0];
			item_s1.param_byte <= s_tdata[15:8];
			item_s1.has_param  <= s_tdata[16];
		end
	end

	ewms_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg_q),
		.req    (req)
	);

	ewms_report u_report (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && item_s1.cmd == CMD_QUERY))
		else $error("input stalled without blocked query");

	a_query_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && item_s1.cmd == CMD_QUERY && m_tvalid && !m_tready) |-> !fire)
		else $error("query fired into full report register");

	a_only_query_reports: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid |-> (fire && item_s1.cmd == CMD_QUERY))
		else $error("report from non-query request");

endmodule

/* verif/emulated_wheel_motor_status_core_tb.sv */
// self-checking testbench for emulated_wheel_motor_status_core
// predicts every status report from its own wheel model and compares it field by field
// depends on ewms_pkg and the core; a clocked driver feeds requests from a queue
`timescale 1ns / 1ps

module emulated_wheel_motor_status_core_tb;
	import ewms_pkg::*;

	localparam int HALF_PERIOD   = 5;
	localparam int RESET_CYCLES  = 4;
	// cycles with work outstanding but no handshake before the run is declared hung
	localparam int STALL_LIMIT   = 3000;
	// the core has two stages, so the settle wait covers a tick still in flight
	localparam int SETTLE_CYCLES = 8;
	// long receiver hold-off used to back the core up
	localparam int HOLD_CYCLES   = 200;
	// busy window used to watch busy drop at its edge
	localparam int EDGE_WIN      = 40;

	// one status report as the core packs it on the master side
	typedef struct packed {
		logic [BYTE_W-1:0] code;
		logic              busy;
		logic [BYTE_W-1:0] pos_hi;
		logic [BYTE_W-1:0] pos_lo;
		logic [BYTE_W-1:0] torque;
	} status_rpt_t;

	// dut ports, every input known from time zero
	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic [CMD_W-1:0]      s_tuser   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	// requests waiting for the driver and reports waiting for the core
	item_t       request_queue[$];
	status_rpt_t reports_due[$];

	// wheel model: configuration copy and emulated state
	logic                    cfg_emu    = 1'b0;
	logic [MS_W-1:0]         cfg_win    = BUSY_WIN_RST;
	logic [BYTE_W-1:0]       cfg_torque = TORQUE_RST;
	logic signed [POS_W-1:0] wheel_pos  = '0;
	logic signed [POS_W-1:0] wheel_tgt  = '0;
	logic [MS_W-1:0]         ms_count   = MS_MAX;

	// traffic shaping
	int   src_idle_pct = 0;
	int   snk_idle_pct = 0;
	logic hold_req     = 1'b0;
	int   hold_count   = 0;
	logic src_took     = 1'b0;

	// bookkeeping
	int queued_total   = 0;
	int accepted_total = 0;
	int quiet_cycles   = 0;
	int fail_count     = 0;
	int reports_seen   = 0;
	int busy_seen      = 0;
	int n_cmds         = 0;
	int n_ticks        = 0;
	int n_queries      = 0;
	int n_ignored      = 0;
	int pos_min        = 0;
	int pos_max        = 0;

	emulated_wheel_motor_status_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic logic [BYTE_W-1:0] rand_byte();
		return BYTE_W'($urandom);
	endfunction

	function automatic logic rand_bit();
		return 1'($urandom_range(0, 1));
	endfunction

	// param byte to target: centre codes give 0, low half pulls left, high half right
	function automatic logic signed [POS_W-1:0] target_for_param(input logic [BYTE_W-1:0] p);
		int t;
		t = 0;
		if (p != 8'h00 && p != PARAM_MID) begin
			if (p < PARAM_MID) begin
				t = -50 - int'(p >> 1);
				if (t < int'(POS_NLIMIT))
					t = int'(POS_NLIMIT);
			end else begin
				t = 50 + int'((p - PARAM_MID) >> 1);
				if (t > int'(POS_LIMIT))
					t = int'(POS_LIMIT);
			end
		end
		return t[POS_W-1:0];
	endfunction

	// advance the wheel model by one accepted request, queue a report for a query
	task automatic apply_request(input cmd_t c, input logic [BYTE_W-1:0] op,
			input logic [BYTE_W-1:0] param, input logic has_param);
		status_rpt_t rpt;
		int          p16;
		case (c)
			CMD_BYTES: begin
				n_cmds++;
				ms_count = '0;
				if (has_param) begin
					if (op == OP_SET_TARGET) begin
						wheel_tgt = target_for_param(param);
					end else if (op == OP_INIT) begin
						wheel_pos = '0;
						wheel_tgt = '0;
					end
				end
			end
			CMD_TICK: begin
				n_ticks++;
				if (ms_count < MS_MAX)
					ms_count++;
				if (cfg_emu) begin
					if (wheel_pos < wheel_tgt)
						wheel_pos++;
					else if (wheel_pos > wheel_tgt)
						wheel_pos--;
				end
				if (int'(wheel_pos) < pos_min)
					pos_min = int'(wheel_pos);
				if (int'(wheel_pos) > pos_max)
					pos_max = int'(wheel_pos);
			end
			CMD_QUERY: begin
				n_queries++;
				// position stays within +-100, so the 16-bit value never clips
				p16 = int'(POS_CENTRE) + int'(wheel_pos) * int'(POS_SCALE);
				rpt.code   = REPORT_OK;
				rpt.busy   = (wheel_pos != wheel_tgt) && (ms_count < cfg_win);
				rpt.pos_hi = p16[15:8];
				rpt.pos_lo = p16[7:0];
				rpt.torque = cfg_torque;
				if (rpt.busy)
					busy_seen++;
				reports_due.push_back(rpt);
			end
			default: begin
				// selector 3 is dropped by the core
				n_ignored++;
			end
		endcase
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("report %0d: %s expected 0x%0h, got 0x%0h", reports_seen, name, want, got);
			fail_count++;
		end
	endtask

	// request driver: offers the next queued request once the previous one is taken
	always @(negedge clk) begin : drive_requests
		item_t it;
		if (!s_tvalid || src_took) begin
			if (request_queue.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
				it = request_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {7'd0, it.has_param, it.param_byte, it.first_byte};
				s_tuser  <= it.cmd;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		src_took = 1'b0;
	end

	// report receiver: random stalls, plus one long hold-off when asked for
	always @(negedge clk) begin : drive_ready
		if (hold_req && hold_count < HOLD_CYCLES) begin
			hold_count++;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
		end
	end

	// monitor: checks reports against the model, feeds accepted requests into it
	always @(posedge clk) begin : watch_ports
		status_rpt_t want;
		status_rpt_t got;
		logic        moved;
		if (arst_n) begin
			moved = 1'b0;
			// reports first: a report leaving now belongs to an older request
			if (m_tvalid && m_tready) begin
				moved = 1'b1;
				reports_seen++;
				got.code   = m_tdata[7:0];
				got.busy   = m_tdata[8];
				got.pos_hi = m_tdata[16:9];
				got.pos_lo = m_tdata[24:17];
				got.torque = m_tdata[32:25];
				if (reports_due.size() == 0) begin
					$error("report %0d arrived with none expected", reports_seen);
					fail_count++;
				end else begin
					want = reports_due.pop_front();
					check_field("report_code", int'(want.code), int'(got.code));
					check_field("motor_busy", int'(want.busy), int'(got.busy));
					check_field("position_high", int'(want.pos_hi), int'(got.pos_hi));
					check_field("position_low", int'(want.pos_lo), int'(got.pos_lo));
					check_field("torque_out", int'(want.torque), int'(got.torque));
				end
			end
			if (s_tvalid && s_tready) begin
				moved = 1'b1;
				apply_request(cmd_t'(s_tuser), s_tdata[7:0], s_tdata[15:8], s_tdata[16]);
				accepted_total++;
				src_took = 1'b1;
			end
			// watchdog only runs while something is still owed
			if (moved || (accepted_total == queued_total && reports_due.size() == 0))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("no handshake for %0d cycles, %0d reports still owed",
					STALL_LIMIT, reports_due.size());
				$display("emulated_wheel_motor_status_core_tb: errors");
				$finish;
			end
		end
	end

	task automatic queue_request(input cmd_t c, input logic [BYTE_W-1:0] fb,
			input logic [BYTE_W-1:0] pb, input logic hp);
		item_t it;
		it.cmd        = c;
		it.first_byte = fb;
		it.param_byte = pb;
		it.has_param  = hp;
		request_queue.push_back(it);
		queued_total++;
	endtask

	// block until every request is taken and every report is in, then let ticks settle
	task automatic wait_drained();
		while (accepted_total != queued_total || reports_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// register write while the core is idle; model follows immediately
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_EMU_EN:   cfg_emu    = val[0];
			CFG_BUSY_WIN: cfg_win    = val[MS_W-1:0];
			CFG_TORQUE:   cfg_torque = val[BYTE_W-1:0];
			default:      ;
		endcase
	endtask

	// mostly well-formed motion runs (command, ticks, queries), the rest loose noise
	task automatic add_random(input int n);
		int   made;
		int   run_len;
		cmd_t c;
		made = 0;
		while (made < n) begin
			if ($urandom_range(0, 99) < 75) begin
				if ($urandom_range(0, 5) == 0)
					queue_request(CMD_BYTES, OP_INIT, rand_byte(), 1'b1);
				else
					queue_request(CMD_BYTES, OP_SET_TARGET, rand_byte(), 1'b1);
				made++;
				// occasional long run so the wheel reaches full lock
				run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 140)
					: $urandom_range(0, 40);
				for (int j = 0; j < run_len; j++) begin
					queue_request(CMD_TICK, rand_byte(), rand_byte(), rand_bit());
					made++;
					if ($urandom_range(0, 3) == 0) begin
						queue_request(CMD_QUERY, rand_byte(), rand_byte(), rand_bit());
						made++;
					end
				end
				queue_request(CMD_QUERY, rand_byte(), rand_byte(), rand_bit());
				made++;
			end else begin
				c = cmd_t'($urandom_range(0, 3));
				case ($urandom_range(0, 3))
					0:       queue_request(c, OP_SET_TARGET, rand_byte(), rand_bit());
					1:       queue_request(c, OP_INIT, rand_byte(), rand_bit());
					default: queue_request(c, rand_byte(), rand_byte(), rand_bit());
				endcase
				if (c != CMD_NONE)
					made++;
			end
		end
	endtask

	task automatic run_phase(input logic emu, input logic [MS_W-1:0] win,
			input logic [BYTE_W-1:0] torque, input int src_pct, input int snk_pct,
			input int n);
		wait_drained();
		write_reg(CFG_EMU_EN, CFG_DATA_W'(emu));
		write_reg(CFG_BUSY_WIN, win);
		write_reg(CFG_TORQUE, CFG_DATA_W'(torque));
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		add_random(n);
	endtask

	initial begin : stimulus
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part on reset configuration: reset state, target decode corners,
		// short and unknown commands, dropped selector, ticks with emulation off
		queue_request(CMD_QUERY, 8'h00, 8'h00, 1'b0);
		queue_request(CMD_TICK, 8'hFF, 8'hFF, 1'b1);      // counter already saturated
		queue_request(CMD_QUERY, 8'hFF, 8'hFF, 1'b1);
		queue_request(CMD_BYTES, OP_SET_TARGET, 8'h00, 1'b1);
		queue_request(CMD_BYTES, OP_SET_TARGET, PARAM_MID, 1'b1);
		queue_request(CMD_BYTES, OP_SET_TARGET, 8'h01, 1'b1);
		queue_request(CMD_QUERY, 8'h00, 8'h00, 1'b0);
		queue_request(CMD_BYTES, OP_SET_TARGET, 8'h7F, 1'b1); // clamps left
		queue_request(CMD_BYTES, OP_SET_TARGET, 8'hFF, 1'b1); // clamps right
		queue_request(CMD_QUERY, 8'h00, 8'h00, 1'b0);
		queue_request(CMD_BYTES, OP_SET_TARGET, 8'h81, 1'b1);
		queue_request(CMD_BYTES, OP_SET_TARGET, 8'hFF, 1'b0); // no second byte
		queue_request(CMD_BYTES, OP_INIT, 8'h00, 1'b0);       // no second byte
		queue_request(CMD_QUERY, 8'h00, 8'h00, 1'b0);
		queue_request(CMD_BYTES, 8'h55, 8'hAA, 1'b1);         // unknown opcode
		queue_request(CMD_QUERY, 8'h00, 8'h00, 1'b0);
		queue_request(CMD_BYTES, OP_INIT, 8'h7F, 1'b1);
		queue_request(CMD_QUERY, 8'h00, 8'h00, 1'b0);
		queue_request(CMD_NONE, OP_SET_TARGET, 8'hFF, 1'b1);
		queue_request(CMD_TICK, 8'h00, 8'h00, 1'b0);
		queue_request(CMD_TICK, 8'h00, 8'h00, 1'b0);
		queue_request(CMD_QUERY, 8'hFF, 8'hFF, 1'b1);

		// random phases across configuration extremes and idle patterns
		run_phase(1'b1, 10'd1, 8'hFF, 0, 0, 170);
		run_phase(1'b1, MS_MAX, 8'h00, 46, 0, 170);
		run_phase(1'b0, 10'd0, 8'hA5, 0, 46, 170);
		run_phase(1'b1, 10'd37, 8'h5A, 37, 37, 170);

		// back-pressure: receiver holds off while queries keep coming
		run_phase(1'b1, BUSY_WIN_RST, TORQUE_RST, 0, 0, 0);
		hold_req = 1'b1;
		queue_request(CMD_BYTES, OP_SET_TARGET, 8'hC0, 1'b1);
		for (int j = 0; j < 80; j++) begin
			if (j % 4 == 0)
				queue_request(CMD_TICK, rand_byte(), rand_byte(), rand_bit());
			else
				queue_request(CMD_QUERY, rand_byte(), rand_byte(), rand_bit());
		end

		// counter walks across the window: busy must drop exactly at its edge
		run_phase(1'b0, MS_W'(EDGE_WIN), 8'h3C, 0, 0, 0);
		queue_request(CMD_BYTES, OP_INIT, 8'h00, 1'b1);
		queue_request(CMD_BYTES, OP_SET_TARGET, 8'hFF, 1'b1);
		for (int j = 0; j < EDGE_WIN - 3; j++)
			queue_request(CMD_TICK, rand_byte(), rand_byte(), rand_bit());
		for (int j = 0; j < 6; j++) begin
			queue_request(CMD_QUERY, 8'h00, 8'h00, 1'b0);
			queue_request(CMD_TICK, 8'h00, 8'h00, 1'b0);
		end
		queue_request(CMD_QUERY, 8'h00, 8'h00, 1'b0);

		wait_drained();
		$display("covered %0d commands, %0d ticks, %0d queries, %0d dropped requests",
			n_cmds, n_ticks, n_queries, n_ignored);
		$display("%0d reports checked (%0d busy), wheel travel %0d..%0d, %0d failures",
			reports_seen, busy_seen, pos_min, pos_max, fail_count);
		if (fail_count == 0) begin
			$display("emulated_wheel_motor_status_core_tb: clean");
		end else begin
			$display("emulated_wheel_motor_status_core_tb: errors");
		end
		$finish;
	end

endmodule

/* emulated_wheel_motor_status_core.f */
sv/ewms_pkg.sv
sv/ewms_state.sv
sv/ewms_report.sv
sv/emulated_wheel_motor_status_core.sv
verif/emulated_wheel_motor_status_core_tb.sv
